>>> rtl/source_text_tokenizer_unit_assert.svh
// Assertion macros for the source text tokenizer.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STT_ASSERT(lbl, prop, msg)
`define STT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/stt_pkg.sv
// Shared types, token kind codes and keyword table of the source text tokenizer.
// No dependencies; every other file of the block but the assert header imports it.
`default_nettype none

package stt_pkg;

  localparam int DEF_OFFSET_WIDTH  = 24;
  localparam int DEF_LINE_WIDTH    = 20;
  localparam int DEF_COLUMN_WIDTH  = 16;
  localparam int DEF_KEYWORD_BYTES = 8;
  localparam int DEF_RESULT_DEPTH  = 4;

  localparam int BYTE_W       = 8;
  localparam int KIND_W       = 6;
  localparam int OUT_OFFSET_W = 24;
  localparam int OUT_LINE_W   = 20;
  localparam int OUT_COL_W    = 16;

  localparam logic [BYTE_W-1:0] CH_NL         = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_END      = 6'd0;
  localparam kind_t KIND_LPAREN   = 6'd1;
  localparam kind_t KIND_RPAREN   = 6'd2;
  localparam kind_t KIND_PLUS     = 6'd3;
  localparam kind_t KIND_MINUS    = 6'd4;
  localparam kind_t KIND_STAR     = 6'd5;
  localparam kind_t KIND_SLASH    = 6'd6;
  localparam kind_t KIND_SEMI     = 6'd7;
  localparam kind_t KIND_COLON    = 6'd8;
  localparam kind_t KIND_ASSIGN   = 6'd9;
  localparam kind_t KIND_EQ_EQ    = 6'd10;
  localparam kind_t KIND_LBRACE   = 6'd11;
  localparam kind_t KIND_RBRACE   = 6'd12;
  localparam kind_t KIND_GT       = 6'd13;
  localparam kind_t KIND_GE       = 6'd14;
  localparam kind_t KIND_LT       = 6'd15;
  localparam kind_t KIND_LE       = 6'd16;
  localparam kind_t KIND_OR_OR    = 6'd17;
  localparam kind_t KIND_AND_AND  = 6'd18;
  localparam kind_t KIND_BANG     = 6'd19;
  localparam kind_t KIND_NE       = 6'd20;
  localparam kind_t KIND_INT      = 6'd21;
  localparam kind_t KIND_IDENT    = 6'd22;
  localparam kind_t KIND_KW_FIRST = 6'd23;
  localparam kind_t KIND_ERR_CHAR = 6'd31;
  localparam kind_t KIND_ERR_LONE = 6'd32;

  typedef enum logic [11:0] {
    MODE_IDLE    = 12'b0000_0000_0001,
    MODE_SLASH   = 12'b0000_0000_0010,
    MODE_COMMENT = 12'b0000_0000_0100,
    MODE_EQ      = 12'b0000_0000_1000,
    MODE_GT      = 12'b0000_0001_0000,
    MODE_LT      = 12'b0000_0010_0000,
    MODE_BAR     = 12'b0000_0100_0000,
    MODE_AMP     = 12'b0000_1000_0000,
    MODE_BANG    = 12'b0001_0000_0000,
    MODE_INT     = 12'b0010_0000_0000,
    MODE_IDENT   = 12'b0100_0000_0000,
    MODE_ERROR   = 12'b1000_0000_0000
  } mode_t;

  localparam int KW_COUNT   = 8;
  localparam int KW_MAX_LEN = 8;

  // Keywords in priority order: print, let, int, if, else, while, continue, break.
  localparam logic [BYTE_W-1:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00}
  };
  localparam int KW_LEN [KW_COUNT] = '{5, 3, 3, 2, 4, 5, 8, 5};

  typedef struct packed {
    kind_t                   token_kind;
    logic [OUT_OFFSET_W-1:0] start_offset;
    logic [OUT_OFFSET_W-1:0] token_length;
    logic [OUT_LINE_W-1:0]   line_number;
    logic [OUT_COL_W-1:0]    column_number;
    logic                    last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } results_t;

endpackage

`default_nettype wire

>>> rtl/stt_in_if.sv
// Request channel carrying source bytes and the end marker into the tokenizer.
// Depends on stt_pkg for the byte width.
`default_nettype none

interface stt_in_if;
  import stt_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              end_marker;

  modport source (output valid, byte_value, end_marker, input ready);
  modport sink (input valid, byte_value, end_marker, output ready);
endinterface

`default_nettype wire

>>> rtl/stt_out_if.sv
// Request channel carrying tokens out of the tokenizer.
// Depends on stt_pkg for the field widths.
`default_nettype none

interface stt_out_if;
  import stt_pkg::*;

  logic                    valid;
  logic                    ready;
  kind_t                   token_kind;
  logic [OUT_OFFSET_W-1:0] start_offset;
  logic [OUT_OFFSET_W-1:0] token_length;
  logic [OUT_LINE_W-1:0]   line_number;
  logic [OUT_COL_W-1:0]    column_number;
  logic                    last_of_run;

  modport source (
    output valid, token_kind, start_offset, token_length, line_number, column_number,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, token_kind, start_offset, token_length, line_number, column_number,
           last_of_run,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/stt_result_fifo.sv
// Small register queue of tokens: takes up to two per cycle, gives one per cycle.
// Depends on stt_pkg for the token and result group types.
`default_nettype none

module stt_result_fifo #(
  parameter int DEPTH = stt_pkg::DEF_RESULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stt_pkg::results_t push,
  input  logic              pop,
  output stt_pkg::token_t   head,
  output logic              not_empty,
  output logic              room_for_two
);
  import stt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  token_t            mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  wr_ptr_one;

  assign wr_ptr_one   = ptr_inc(wr_ptr_r);
  assign head         = mem_r[rd_ptr_r];
  assign not_empty    = (count_r != '0);
  assign room_for_two = (count_r <= CNT_W'(DEPTH - 2));

  always_comb begin
    unique case (push.count)
      2'd1:    wr_ptr_nxt = wr_ptr_one;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_one);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_one] <= push.second;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stt_lexer.sv
// Scanner state, position counters and keyword buffer; lexes one byte per enabled cycle.
// Depends on stt_pkg for mode, kind codes, keyword table and result types.
`default_nettype none

module stt_lexer #(
  parameter int OFFSET_WIDTH  = stt_pkg::DEF_OFFSET_WIDTH,
  parameter int LINE_WIDTH    = stt_pkg::DEF_LINE_WIDTH,
  parameter int COLUMN_WIDTH  = stt_pkg::DEF_COLUMN_WIDTH,
  parameter int KEYWORD_BYTES = stt_pkg::DEF_KEYWORD_BYTES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic [stt_pkg::BYTE_W-1:0] byte_value,
  input  logic                      end_marker,
  output stt_pkg::results_t         results
);
  import stt_pkg::*;

  localparam int KIDX_W = $clog2(KEYWORD_BYTES);

  function automatic kind_t single_kind(input logic [BYTE_W-1:0] ch);
    unique case (ch)
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      "*":     return KIND_STAR;
      ";":     return KIND_SEMI;
      ":":     return KIND_COLON;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      default: return KIND_END;
    endcase
  endfunction

  function automatic mode_t start_mode(input logic [BYTE_W-1:0] ch);
    unique case (ch)
      "/":     return MODE_SLASH;
      "=":     return MODE_EQ;
      ">":     return MODE_GT;
      "<":     return MODE_LT;
      "|":     return MODE_BAR;
      "&":     return MODE_AMP;
      "!":     return MODE_BANG;
      default: return MODE_IDLE;
    endcase
  endfunction

  mode_t                    mode_r, mode_nxt;
  logic [OFFSET_WIDTH-1:0]  off_r, off_nxt;
  logic [LINE_WIDTH-1:0]    line_r, line_nxt;
  logic [COLUMN_WIDTH-1:0]  col_r, col_nxt;
  logic [OFFSET_WIDTH-1:0]  tso_r, tso_nxt;
  logic [COLUMN_WIDTH-1:0]  tsc_r, tsc_nxt;
  logic [BYTE_W-1:0]        kbuf_r [KEYWORD_BYTES];

  logic                     is_nl, is_ws, is_dig, is_alpha;
  kind_t                    sk;
  mode_t                    sm;
  logic [OFFSET_WIDTH-1:0]  off_inc, held_len, pair_len, fresh_len;
  logic [LINE_WIDTH-1:0]    line_step;
  logic [COLUMN_WIDTH-1:0]  col_step;
  kind_t                    kw_kind;

  logic                     kb_we;
  logic [KIDX_W-1:0]        kb_idx;
  logic                     redo, pair_mode, pair_hit, bar_hit;
  logic                     a_en, b_en;
  kind_t                    a_kind, b_kind;
  logic [OFFSET_WIDTH-1:0]  a_len, b_len;
  token_t                   tok_a, tok_b;

  assign is_nl    = (byte_value == CH_NL);
  assign is_ws    = (byte_value == " ") || (byte_value >= 8'h09 && byte_value <= 8'h0D);
  assign is_dig   = (byte_value >= "0") && (byte_value <= "9");
  assign is_alpha = ((byte_value >= "a") && (byte_value <= "z")) ||
                    ((byte_value >= "A") && (byte_value <= "Z")) ||
                    (byte_value == CH_UNDERSCORE);
  assign sk       = single_kind(byte_value);
  assign sm       = start_mode(byte_value);

  assign off_inc   = (&off_r) ? off_r : off_r + 1'b1;
  assign line_step = !is_nl ? line_r : ((&line_r) ? line_r : line_r + 1'b1);
  assign col_step  = is_nl ? '0 : ((&col_r) ? col_r : col_r + 1'b1);
  assign held_len  = off_r - tso_r;
  assign pair_len  = off_inc - tso_r;
  assign fresh_len = off_inc - off_r;

  // Keyword match over the buffered first bytes; the earliest keyword in the table wins.
  always_comb begin
    logic hit;
    logic found;
    found   = 1'b0;
    kw_kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = (held_len == OFFSET_WIDTH'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < KW_LEN[k] && kbuf_r[i] != KW_TEXT[k][i]) begin
          hit = 1'b0;
        end
      end
      if (hit && !found) begin
        found   = 1'b1;
        kw_kind = KIND_KW_FIRST + kind_t'(k);
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    off_nxt   = off_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tso_nxt   = tso_r;
    tsc_nxt   = tsc_r;
    kb_we     = 1'b0;
    kb_idx    = held_len[KIDX_W-1:0];
    redo      = 1'b0;
    pair_mode = 1'b0;
    pair_hit  = (byte_value == "=");
    bar_hit   = 1'b0;
    a_en      = 1'b0;
    a_kind    = KIND_END;
    a_len     = held_len;
    b_en      = 1'b0;
    b_kind    = KIND_END;
    b_len     = fresh_len;

    if (step_en && end_marker) begin
      // A pending token is flushed, then the end token; every counter restarts.
      unique case (mode_r)
        MODE_SLASH: begin a_en = 1'b1; a_kind = KIND_SLASH; end
        MODE_EQ:    begin a_en = 1'b1; a_kind = KIND_ASSIGN; end
        MODE_GT:    begin a_en = 1'b1; a_kind = KIND_GT; end
        MODE_LT:    begin a_en = 1'b1; a_kind = KIND_LT; end
        MODE_BANG:  begin a_en = 1'b1; a_kind = KIND_BANG; end
        MODE_BAR, MODE_AMP: begin
          a_en   = 1'b1;
          a_kind = KIND_ERR_LONE;
          a_len  = OFFSET_WIDTH'(1);
        end
        MODE_INT:   begin a_en = 1'b1; a_kind = KIND_INT; end
        MODE_IDENT: begin a_en = 1'b1; a_kind = kw_kind; end
        default:    a_en = 1'b0;
      endcase
      b_en     = 1'b1;
      b_kind   = KIND_END;
      b_len    = '0;
      mode_nxt = MODE_IDLE;
      off_nxt  = '0;
      line_nxt = '0;
      col_nxt  = '0;
      tso_nxt  = '0;
      tsc_nxt  = '0;
    end else if (step_en) begin
      off_nxt  = off_inc;
      line_nxt = line_step;
      col_nxt  = col_step;
      unique case (mode_r)
        MODE_IDLE: redo = 1'b1;
        MODE_SLASH: begin
          if (byte_value == "/") begin
            mode_nxt = MODE_COMMENT;
          end else begin
            a_en   = 1'b1;
            a_kind = KIND_SLASH;
            redo   = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (is_nl) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_EQ: begin
          pair_mode = 1'b1;
          a_kind    = pair_hit ? KIND_EQ_EQ : KIND_ASSIGN;
        end
        MODE_GT: begin
          pair_mode = 1'b1;
          a_kind    = pair_hit ? KIND_GE : KIND_GT;
        end
        MODE_LT: begin
          pair_mode = 1'b1;
          a_kind    = pair_hit ? KIND_LE : KIND_LT;
        end
        MODE_BANG: begin
          pair_mode = 1'b1;
          a_kind    = pair_hit ? KIND_NE : KIND_BANG;
        end
        MODE_BAR, MODE_AMP: begin
          bar_hit = (mode_r == MODE_BAR) ? (byte_value == "|") : (byte_value == "&");
          a_en    = 1'b1;
          if (bar_hit) begin
            a_kind   = (mode_r == MODE_BAR) ? KIND_OR_OR : KIND_AND_AND;
            a_len    = pair_len;
            mode_nxt = MODE_IDLE;
          end else begin
            a_kind   = KIND_ERR_LONE;
            a_len    = OFFSET_WIDTH'(1);
            mode_nxt = MODE_ERROR;
          end
        end
        MODE_INT: begin
          if (!is_dig) begin
            a_en   = 1'b1;
            a_kind = KIND_INT;
            redo   = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (is_alpha || is_dig) begin
            kb_we = (held_len < OFFSET_WIDTH'(KEYWORD_BYTES));
          end else begin
            a_en   = 1'b1;
            a_kind = kw_kind;
            redo   = 1'b1;
          end
        end
        default: mode_nxt = MODE_ERROR;
      endcase

      if (pair_mode) begin
        a_en = 1'b1;
        if (pair_hit) begin
          a_len    = pair_len;
          mode_nxt = MODE_IDLE;
        end else begin
          redo = 1'b1;
        end
      end

      // A byte seen in the idle state, or one that ended a pending token, is lexed afresh from the idle state.
      if (redo) begin
        if (!is_ws) begin
          tso_nxt = off_r;
          tsc_nxt = col_r;
        end
        mode_nxt = MODE_IDLE;
        priority if (is_ws) begin
          mode_nxt = MODE_IDLE;
        end else if (sk != KIND_END) begin
          b_en   = 1'b1;
          b_kind = sk;
        end else if (sm != MODE_IDLE) begin
          mode_nxt = sm;
        end else if (is_dig) begin
          mode_nxt = MODE_INT;
        end else if (is_alpha) begin
          mode_nxt = MODE_IDENT;
          kb_we    = 1'b1;
          kb_idx   = '0;
        end else begin
          b_en     = 1'b1;
          b_kind   = KIND_ERR_CHAR;
          mode_nxt = MODE_ERROR;
        end
      end
    end
  end

  always_comb begin
    tok_a.token_kind    = a_kind;
    tok_a.start_offset  = OUT_OFFSET_W'(tso_r);
    tok_a.token_length  = OUT_OFFSET_W'(a_len);
    tok_a.line_number   = OUT_LINE_W'(line_r);
    tok_a.column_number = OUT_COL_W'(tsc_r);
    tok_a.last_of_run   = !b_en;

    tok_b.token_kind    = b_kind;
    tok_b.start_offset  = OUT_OFFSET_W'(off_r);
    tok_b.token_length  = OUT_OFFSET_W'(b_len);
    tok_b.line_number   = OUT_LINE_W'(line_r);
    tok_b.column_number = OUT_COL_W'(col_r);
    tok_b.last_of_run   = 1'b1;

    results.second = tok_b;
    if (a_en) begin
      results.first = tok_a;
      results.count = b_en ? 2'd2 : 2'd1;
    end else begin
      results.first = tok_b;
      results.count = b_en ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      off_r  <= '0;
      line_r <= '0;
      col_r  <= '0;
      tso_r  <= '0;
      tsc_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      off_r  <= off_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tso_r  <= tso_nxt;
      tsc_r  <= tsc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (kb_we) begin
      kbuf_r[kb_idx] <= byte_value;
    end
  end

endmodule

`default_nettype wire

>>> rtl/source_text_tokenizer_unit.sv
// Top level of the source text tokenizer: input register, lexer and result queue.
// Depends on stt_pkg, stt_in_if, stt_out_if, stt_lexer, stt_result_fifo and the assert header.
//
// The tokenizer takes one source byte, or the end marker, per request and turns the stream
// into tokens with kind, start offset, length, line and start column. A request is
// accepted every cycle while the result queue has room for two tokens; it waits in the input
// register, is lexed once the queue has room, and its tokens reach the output the cycle after.
// Each request yields zero, one or two tokens, and the output drains one token per cycle while
// the output is ready, so the sustained rate is one byte per cycle and falls only while the
// requests yield tokens faster than the output takes them.
// Whitespace and line comments yield nothing; after an error token nothing is emitted
// until the end marker, which always closes with an end token and restarts the counters.
`default_nettype none

module source_text_tokenizer_unit #(
  parameter int OFFSET_WIDTH  = stt_pkg::DEF_OFFSET_WIDTH,
  parameter int LINE_WIDTH    = stt_pkg::DEF_LINE_WIDTH,
  parameter int COLUMN_WIDTH  = stt_pkg::DEF_COLUMN_WIDTH,
  parameter int KEYWORD_BYTES = stt_pkg::DEF_KEYWORD_BYTES,
  parameter int RESULT_DEPTH  = stt_pkg::DEF_RESULT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);
  import stt_pkg::*;

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_end_r;
  logic              process;
  logic              room_for_two;
  logic              not_empty;
  logic              pop;
  results_t          lex_res;
  token_t            head;

  assign process       = in_valid_r && room_for_two;
  assign in_chan.ready = !in_valid_r || process;
  assign pop           = not_empty && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.byte_value;
      in_end_r  <= in_chan.end_marker;
    end
  end

  stt_lexer #(
    .OFFSET_WIDTH  (OFFSET_WIDTH),
    .LINE_WIDTH    (LINE_WIDTH),
    .COLUMN_WIDTH  (COLUMN_WIDTH),
    .KEYWORD_BYTES (KEYWORD_BYTES)
  ) u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (process),
    .byte_value (in_byte_r),
    .end_marker (in_end_r),
    .results    (lex_res)
  );

  stt_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_result_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (lex_res),
    .pop          (pop),
    .head         (head),
    .not_empty    (not_empty),
    .room_for_two (room_for_two)
  );

  assign out_chan.valid         = not_empty;
  assign out_chan.token_kind    = head.token_kind;
  assign out_chan.start_offset  = head.start_offset;
  assign out_chan.token_length  = head.token_length;
  assign out_chan.line_number   = head.line_number;
  assign out_chan.column_number = head.column_number;
  assign out_chan.last_of_run   = head.last_of_run;

`include "source_text_tokenizer_unit_assert.svh"

  `STT_ASSERT(a_held_request_stays, in_valid_r && !process |=> in_valid_r && $stable(in_byte_r) && $stable(in_end_r), "stalled request lost from the input register")
  `STT_ASSERT(a_end_closes_run, process && in_end_r |-> lex_res.count != 2'd0 && ((lex_res.count == 2'd2) ? (lex_res.second.token_kind == KIND_END) : (lex_res.first.token_kind == KIND_END)), "end marker did not close with an end token")
  `STT_ASSERT_ALWAYS(a_pair_marks_last, lex_res.count == 2'd2 |-> !lex_res.first.last_of_run && lex_res.second.last_of_run, "last_of_run misplaced in a token pair")

endmodule

`default_nettype wire
